### hw/rtl/obrb_pkg.sv
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared types and constants for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

   // Width of the capacity write data and of the free slot count.
   localparam int CAP_W = 11;

   // Capacity after reset, before clamping to the ring depth.
   localparam int CAP_RESET = 1024;

   // Operation codes of a request transaction.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Result status handed from the pointer control to the top level.
   typedef struct packed {
      logic             rsp_valid;
      logic             read_valid;
      logic             overwrote;
      logic             is_empty;
      logic             is_full;
      logic [CAP_W-1:0] free_slots;
   } status_type;

endpackage

### hw/rtl/obrb_store.sv
// ----------------------------------------------------------------------------
// obrb_store
// Byte storage of the ring: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module obrb_store #(
   parameter int DEPTH = 1024,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/obrb_ctrl.sv
// ----------------------------------------------------------------------------
// obrb_ctrl
// Pointer control of the ring: capacity register, write and read pointers,
// full flag, store port control and result status.
// ----------------------------------------------------------------------------
module obrb_ctrl #(
   parameter int DEPTH = 1024,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CW = (PTR_W + 1 > obrb_pkg::CAP_W) ? PTR_W + 1 : obrb_pkg::CAP_W,
   localparam int CAP_RST = (DEPTH < obrb_pkg::CAP_RESET) ? DEPTH : obrb_pkg::CAP_RESET
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic                       csr_wr_en,
   input  logic [obrb_pkg::CAP_W-1:0] csr_wr_data,
   output logic                       mem_wr_en,
   output logic [PTR_W-1:0]           mem_wr_addr,
   output logic                       mem_rd_en,
   output logic [PTR_W-1:0]           mem_rd_addr,
   output obrb_pkg::status_type       status
);

   logic [CW-1:0]    cap_ff, cap_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic             full_ff, full_in;
   logic             busy_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             read_valid_ff, read_valid_in;
   logic             overwrote_ff, overwrote_in;
   logic             accept;
   logic             empty_now;
   logic [CW-1:0]    cap_wr;
   logic [CW-1:0]    free_w;

   // Advance a pointer, wrapping at the capacity in use.
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CW-1:0] cap);
      logic [CW-1:0] n;
      n = CW'(p) + CW'(1);
      next_ptr = (n >= cap) ? '0 : n[PTR_W-1:0];
   endfunction

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign empty_now = !full_ff && (wr_ff == rd_ff);

   // Clamp a written capacity to the range one to the ring depth.
   always_comb begin
      cap_wr = CW'(csr_wr_data);
      priority if (cap_wr == '0) begin
         cap_wr = CW'(1);
      end else if (cap_wr > CW'(DEPTH)) begin
         cap_wr = CW'(DEPTH);
      end else begin
         cap_wr = CW'(csr_wr_data);
      end
   end

   // Next state of the capacity, the pointers, the full flag and the response flags.
   always_comb begin
      cap_in        = cap_ff;
      wr_in         = wr_ff;
      rd_in         = rd_ff;
      full_in       = full_ff;
      read_valid_in = 1'b0;
      overwrote_in  = 1'b0;
      rsp_valid_in  = accept;
      priority if (csr_wr_en) begin
         cap_in  = cap_wr;
         wr_in   = '0;
         rd_in   = '0;
         full_in = 1'b0;
      end else if (accept) begin
         if (req_func == obrb_pkg::FUNC_WRITE) begin
            // A write into a full ring drops the oldest byte.
            if (full_ff) begin
               rd_in        = next_ptr(rd_ff, cap_ff);
               overwrote_in = 1'b1;
            end
            wr_in   = next_ptr(wr_ff, cap_ff);
            full_in = (wr_in == rd_in);
         end else if (!empty_now) begin
            rd_in         = next_ptr(rd_ff, cap_ff);
            full_in       = 1'b0;
            read_valid_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CW'(CAP_RST);
         wr_ff         <= '0;
         rd_ff         <= '0;
         full_ff       <= 1'b0;
         busy_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         read_valid_ff <= 1'b0;
         overwrote_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         wr_ff         <= wr_in;
         rd_ff         <= rd_in;
         full_ff       <= full_in;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= rsp_valid_in;
         read_valid_ff <= read_valid_in;
         overwrote_ff  <= overwrote_in;
      end
   end

   // Store port control: the read always fetches the oldest byte.
   assign mem_wr_en   = accept && (req_func == obrb_pkg::FUNC_WRITE);
   assign mem_wr_addr = wr_ff;
   assign mem_rd_en   = accept;
   assign mem_rd_addr = rd_ff;

   // Free slots from the pointers after the last transaction.
   always_comb begin
      priority if (full_ff) begin
         free_w = '0;
      end else if (wr_ff >= rd_ff) begin
         free_w = cap_ff - CW'(wr_ff) + CW'(rd_ff);
      end else begin
         free_w = CW'(rd_ff) - CW'(wr_ff);
      end
   end

   assign status.rsp_valid  = rsp_valid_ff;
   assign status.read_valid = read_valid_ff;
   assign status.overwrote  = overwrote_ff;
   assign status.is_empty   = empty_now;
   assign status.is_full    = full_ff;
   assign status.free_slots = free_w[obrb_pkg::CAP_W-1:0];

endmodule

### hw/rtl/overwriting_byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Byte ring buffer that overwrites the oldest byte when written while full.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction (start high while busy is low) carries req_func
// (write or read one byte) and req_write_byte. Exactly one response
// transaction follows in the next cycle, marked by rsp_valid for one cycle:
// the byte read (zero unless rsp_read_valid), the overwrite flag, and the
// empty flag, full flag and free slot count after the operation.
// A new request is taken every cycle once busy is low, as the pointer
// update completes in the accepting cycle and the byte memory, with separate
// write and read ports, reads the oldest byte into a register.
// The receiver cannot stall; responses must be taken as they appear.
// csr_wr_en writes the capacity (clamped to 1..DEPTH) and empties the ring;
// write it only while no request is in flight.
// Reset empties the ring, sets the capacity to 1024 (or DEPTH if smaller)
// and holds busy high until the cycle after reset. The byte memory is not
// cleared; only bytes written since the ring was last emptied are read.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [7:0]                 req_write_byte,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_read_byte,
   output logic                       rsp_read_valid,
   output logic                       rsp_overwrote_oldest,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full_now,
   output logic [obrb_pkg::CAP_W-1:0] rsp_free_slots,
   input  logic                       csr_wr_en,
   input  logic [obrb_pkg::CAP_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);

   logic                 mem_wr_en;
   logic [PTR_W-1:0]     mem_wr_addr;
   logic                 mem_rd_en;
   logic [PTR_W-1:0]     mem_rd_addr;
   logic [7:0]           mem_rd_data;
   obrb_pkg::status_type status;

   // Pointer control.
   obrb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_func    (req_func),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .status      (status)
   );

   // Byte memory.
   obrb_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_write_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response transaction.
   assign rsp_valid            = status.rsp_valid;
   assign rsp_read_byte        = status.read_valid ? mem_rd_data : 8'h00;
   assign rsp_read_valid       = status.read_valid;
   assign rsp_overwrote_oldest = status.overwrote;
   assign rsp_is_empty         = status.is_empty;
   assign rsp_is_full_now      = status.is_full;
   assign rsp_free_slots       = status.free_slots;

`ifndef SYNTHESIS
   // Every accepted request yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_wr_en) |=> rsp_valid)
      else $error("request accepted without a response");

   // A read result or an overwrite only appears with the strobe.
   a_flags_strobed: assert property (@(posedge clock) disable iff (reset)
      (rsp_read_valid || rsp_overwrote_oldest) |-> rsp_valid)
      else $error("result flag outside a response");

   // An overwrite leaves the ring full with no free slots.
   a_overwrite_full: assert property (@(posedge clock) disable iff (reset)
      rsp_overwrote_oldest |-> (rsp_is_full_now && rsp_free_slots == '0))
      else $error("overwrite did not leave the ring full");

   // Full and empty never hold together.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(rsp_is_full_now && rsp_is_empty))
      else $error("ring reported full and empty");
`endif

endmodule
